>>> rtl/windowed_pid_controller_top_macros.svh
// assertion macros shared by the controller
`ifndef WINDOWED_PID_CONTROLLER_TOP_MACROS_SVH
`define WINDOWED_PID_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication, quiet while reset is high
`define WPID_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);

// next-cycle implication, quiet while reset is high
`define WPID_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

>>> rtl/wpid_pkg.sv
// shared types and constants of the windowed pid controller
package wpid_pkg;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_ZERO_DT = 2'd2;
  localparam logic [1:0] ST_CLEARED = 2'd3;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_K     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TERMS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WHOLE        = 3'd5;

  localparam logic [25:0] ABS_MAX = 26'h3FFFFFF;

  // widest window sum for the deepest history, also the serial loop length
  localparam int SUM_W = 33;
  localparam int STEP_W = 6;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] error_sample;
    logic [15:0]        dt_ticks;
  } in_t;

  typedef struct packed {
    logic signed [31:0] command;
    logic [1:0]         status;
    logic [10:0]        history_count;
    logic [25:0]        abs_error_sum;
  } out_t;

  typedef struct packed {
    logic signed [31:0] offset_k;
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
    logic [10:0]        window_terms;
    logic               whole_history;
  } cfg_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [15:0]      e;
    logic signed [15:0]      prev;
    logic [15:0]             dt;
    logic signed [SUM_W-1:0] wsum;
    logic [10:0]             count;
    logic [25:0]             abs_sum;
  } job_t;

endpackage

>>> rtl/windowed_pid_controller_top.sv
// top level of the windowed pid controller
// A sample item is registered in the front end, where the history update and
// the registered prefix-sum read that yields the window sum happen together,
// and waits in a two-entry queue. The back end turns a sample with a nonzero
// time step into a command by the 33-step loop that runs the integral multiply
// (shift-add over the window sum bits) side by side with the restoring divide
// by the time step. Clear items, samples dropped on a full history and samples
// with a zero time step leave the back end in the cycle after it takes them.
// The history is kept as running prefix sums in one memory, so no clearing
// pass is needed after reset.
module windowed_pid_controller_top #(
  parameter int HISTORY_DEPTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  wpid_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output wpid_pkg::out_t                     out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wpid_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_data
);

`include "windowed_pid_controller_top_macros.svh"

  wpid_pkg::cfg_t cfg;
  logic           fq_valid;
  logic           fq_ready;
  wpid_pkg::job_t fq_job;
  logic           qb_valid;
  logic           qb_ready;
  wpid_pkg::job_t qb_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_k <= '0;
      cfg.gain_p <= '0;
      cfg.gain_i <= '0;
      cfg.gain_d <= '0;
      cfg.window_terms <= 11'd1024;
      cfg.whole_history <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wpid_pkg::REG_OFFSET_K:     cfg.offset_k <= cfg_data;
        wpid_pkg::REG_GAIN_P:       cfg.gain_p <= cfg_data[15:0];
        wpid_pkg::REG_GAIN_I:       cfg.gain_i <= cfg_data[15:0];
        wpid_pkg::REG_GAIN_D:       cfg.gain_d <= cfg_data[15:0];
        wpid_pkg::REG_WINDOW_TERMS: cfg.window_terms <= cfg_data[10:0];
        wpid_pkg::REG_WHOLE:        cfg.whole_history <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  wpid_front #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .window_terms (cfg.window_terms),
    .whole_history(cfg.whole_history),
    .job_valid    (fq_valid),
    .job_ready    (fq_ready),
    .job          (fq_job)
  );

  wpid_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(fq_valid),
    .push_ready(fq_ready),
    .push_job  (fq_job),
    .pop_valid (qb_valid),
    .pop_ready (qb_ready),
    .pop_job   (qb_job)
  );

  wpid_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .job_valid(qb_valid),
    .job_ready(qb_ready),
    .job      (qb_job),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  `WPID_ASSERT_NOW(a_no_cmd_on_special, clk, rst, out_valid && (out_data.status != wpid_pkg::ST_OK), out_data.command == 32'sd0, "special status with nonzero command")
  `WPID_ASSERT_NOW(a_clear_empties, clk, rst, out_valid && (out_data.status == wpid_pkg::ST_CLEARED), (out_data.history_count == 11'd0) && (out_data.abs_error_sum == 26'd0), "clear left history behind")
  `WPID_ASSERT_NOW(a_full_count, clk, rst, out_valid && (out_data.status == wpid_pkg::ST_FULL), out_data.history_count == 11'(HISTORY_DEPTH), "full status with short history")
  `WPID_ASSERT_NEXT(a_queue_to_back, clk, rst, qb_valid && qb_ready && (qb_job.status != wpid_pkg::ST_OK), out_valid, "special transaction not shown")

endmodule

>>> rtl/wpid_front.sv
// front end: takes items, keeps the history prefix sums and builds jobs
module wpid_front #(
  parameter int HISTORY_DEPTH = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  wpid_pkg::in_t    in_data,
  input  logic [10:0]      window_terms,
  input  logic             whole_history,
  output logic             job_valid,
  input  logic             job_ready,
  output wpid_pkg::job_t   job
);

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int PW = 16 + AW;
  localparam int CMPW = (CW > 11) ? CW : 11;

  logic [CW-1:0]        count;
  logic signed [PW-1:0] total;
  logic [25:0]          abs_total;
  logic signed [15:0]   prev_err;

  logic signed [PW-1:0] prefix_mem [HISTORY_DEPTH];
  logic signed [PW-1:0] rd_q;

  logic                 pend_valid;
  logic [1:0]           pend_status;
  logic signed [15:0]   pend_e;
  logic signed [15:0]   pend_prev;
  logic [15:0]          pend_dt;
  logic [10:0]          pend_count;
  logic [25:0]          pend_abs;
  logic                 pend_win_read;
  logic                 pend_use_window;
  logic signed [PW-1:0] pend_total;

  logic                 accept;
  logic                 is_clear;
  logic                 full;
  logic                 stored;
  logic signed [15:0]   e;
  logic [CW-1:0]        count_inc;
  logic signed [PW-1:0] total_inc;
  logic [16:0]          abs_e;
  logic [26:0]          abs_add;
  logic [25:0]          abs_inc;
  logic [CMPW-1:0]      win_ext;
  logic                 use_window;
  logic                 win_read;
  logic [AW-1:0]        rd_addr;
  logic [1:0]           status_c;
  logic [CW-1:0]        count_after;
  logic signed [PW-1:0] total_after;
  logic [25:0]          abs_after;
  logic signed [PW-1:0] wsum_c;

  assign in_ready = !pend_valid;
  assign accept = in_valid && in_ready;
  assign e = in_data.error_sample;
  assign is_clear = in_data.kind;
  assign full = (count == CW'(HISTORY_DEPTH));
  assign stored = accept && !is_clear && !full;

  assign count_inc = count + CW'(1);
  assign total_inc = total + PW'(e);
  assign abs_e = e[15] ? (17'd0 - {e[15], e}) : {1'b0, e};
  assign abs_add = {1'b0, abs_total} + 27'(abs_e);
  assign abs_inc = (abs_add > {1'b0, wpid_pkg::ABS_MAX}) ? wpid_pkg::ABS_MAX : abs_add[25:0];

  // the window starts past the oldest entry only when it is shorter than the history
  assign win_ext = CMPW'(window_terms);
  assign use_window = !whole_history && (win_ext < CMPW'(count_inc));
  assign win_read = use_window && (window_terms != 11'd0);
  assign rd_addr = AW'(CMPW'(count) - win_ext);

  always_comb begin
    status_c = wpid_pkg::ST_OK;
    count_after = count_inc;
    total_after = total_inc;
    abs_after = abs_inc;
    if (is_clear) begin
      status_c = wpid_pkg::ST_CLEARED;
      count_after = '0;
      total_after = '0;
      abs_after = '0;
    end else if (full) begin
      status_c = wpid_pkg::ST_FULL;
      count_after = count;
      total_after = total;
      abs_after = abs_total;
    end else if (in_data.dt_ticks == 16'd0) begin
      status_c = wpid_pkg::ST_ZERO_DT;
    end
  end

  always_ff @(posedge clk) begin
    if (stored) begin
      prefix_mem[count[AW-1:0]] <= total_inc;
    end
    if (stored && win_read) begin
      rd_q <= prefix_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
      abs_total <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (pend_valid && job_ready) begin
        pend_valid <= 1'b0;
      end
      if (accept) begin
        pend_valid <= 1'b1;
        count <= count_after;
        total <= total_after;
        abs_total <= abs_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status <= status_c;
      pend_e <= e;
      pend_prev <= (count == '0) ? e : prev_err;
      pend_dt <= in_data.dt_ticks;
      pend_count <= 11'(count_after);
      pend_abs <= abs_after;
      pend_win_read <= win_read;
      pend_use_window <= use_window;
      pend_total <= total_after;
    end
    if (stored) begin
      prev_err <= e;
    end
  end

  assign wsum_c = pend_win_read ? (pend_total - rd_q) :
                  (pend_use_window ? '0 : pend_total);

  assign job_valid = pend_valid;

  always_comb begin
    job.status = pend_status;
    job.e = pend_e;
    job.prev = pend_prev;
    job.dt = pend_dt;
    job.wsum = wpid_pkg::SUM_W'(wsum_c);
    job.count = pend_count;
    job.abs_sum = pend_abs;
  end

endmodule

>>> rtl/wpid_queue.sv
// two-entry job queue between front and back
module wpid_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  wpid_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output wpid_pkg::job_t pop_job
);

  wpid_pkg::job_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;
  logic           push;
  logic           pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid = (fill != 2'd0);
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;
  assign pop_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

>>> rtl/wpid_back.sv
// back end: serial integral multiply and derivative divide, sum, saturate
module wpid_back (
  input  logic           clk,
  input  logic           rst,
  input  wpid_pkg::cfg_t cfg,
  input  logic           job_valid,
  output logic           job_ready,
  input  wpid_pkg::job_t job,
  output logic           out_valid,
  input  logic           out_ready,
  output wpid_pkg::out_t out_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_RUN  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_SAT  = 3'd5;

  localparam int MW = 2 * wpid_pkg::SUM_W;
  localparam int ACCW = MW + 2;
  localparam logic [wpid_pkg::STEP_W-1:0] LAST_STEP = wpid_pkg::STEP_W'(wpid_pkg::SUM_W - 1);

  logic [2:0]                       state;
  wpid_pkg::job_t                   jb;
  logic signed [31:0]               pp;
  logic signed [32:0]               gd;
  logic signed [32:0]               dnum;
  logic                             dneg;
  logic [32:0]                      quo;
  logic [15:0]                      rem;
  logic signed [MW-1:0]             mcand;
  logic [wpid_pkg::SUM_W-1:0]       mplier;
  logic signed [MW-1:0]             macc;
  logic [wpid_pkg::STEP_W-1:0]      step;
  logic signed [ACCW-1:0]           s1;
  logic signed [ACCW-1:0]           s2;

  logic                             take;
  logic signed [15:0]               gain_p;
  logic signed [15:0]               gain_i;
  logic signed [15:0]               gain_d;
  logic signed [16:0]               dt_s;
  logic signed [16:0]               diff;
  logic signed [31:0]               pp_c;
  logic signed [32:0]               gd_c;
  logic signed [32:0]               dnum_c;
  logic [16:0]                      trial;
  logic                             fits;
  logic signed [33:0]               dq;
  logic signed [ACCW-1:0]           acc;
  logic signed [ACCW-9:0]           scaled;
  logic signed [31:0]               cmd;

  assign gain_p = cfg.gain_p;
  assign gain_i = cfg.gain_i;
  assign gain_d = cfg.gain_d;
  assign dt_s = signed'({1'b0, jb.dt});
  assign diff = 17'(jb.e) - 17'(jb.prev);
  assign pp_c = gain_p * jb.e;
  assign gd_c = gain_i * dt_s;
  assign dnum_c = gain_d * diff;

  // restoring divide step on the magnitude
  assign trial = {rem, quo[32]};
  assign fits = (trial >= {1'b0, jb.dt});

  assign dq = dneg ? (34'sd0 - signed'({1'b0, quo})) : signed'({1'b0, quo});
  assign acc = s1 + s2;
  assign scaled = acc[ACCW-1:8];

  always_comb begin
    if (scaled > (ACCW-8)'(32'sh7FFFFFFF)) begin
      cmd = 32'sh7FFFFFFF;
    end else if (scaled < (ACCW-8)'(-33'sh80000000)) begin
      cmd = -32'sh80000000;
    end else begin
      cmd = scaled[31:0];
    end
  end

  assign job_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign take = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_SAT) || (take && (job.status != wpid_pkg::ST_OK))) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take && (job.status == wpid_pkg::ST_OK)) begin
            state <= S_PREP;
          end
        end
        S_PREP: state <= S_LOAD;
        S_LOAD: state <= S_RUN;
        S_RUN: begin
          if (step == LAST_STEP) begin
            state <= S_ADD;
          end
        end
        S_ADD: state <= S_SAT;
        S_SAT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (take) begin
          jb <= job;
          out_data.command <= '0;
          out_data.status <= job.status;
          out_data.history_count <= job.count;
          out_data.abs_error_sum <= job.abs_sum;
        end
      end
      S_PREP: begin
        pp <= pp_c;
        gd <= gd_c;
        dnum <= dnum_c;
      end
      S_LOAD: begin
        dneg <= dnum[32];
        quo <= dnum[32] ? (33'd0 - dnum) : dnum;
        rem <= '0;
        mcand <= MW'(gd);
        mplier <= jb.wsum;
        macc <= '0;
        step <= '0;
      end
      S_RUN: begin
        // top multiplier bit carries negative weight
        if (mplier[0]) begin
          macc <= (step == LAST_STEP) ? (macc - mcand) : (macc + mcand);
        end
        mcand <= mcand <<< 1;
        mplier <= mplier >> 1;
        rem <= fits ? 16'(trial - {1'b0, jb.dt}) : trial[15:0];
        quo <= {quo[31:0], fits};
        step <= step + 1'b1;
      end
      S_ADD: begin
        s1 <= (ACCW'(cfg.offset_k) <<< 8) + ACCW'(pp);
        s2 <= ACCW'(macc) + ACCW'(dq);
      end
      S_SAT: begin
        out_data.command <= cmd;
        out_data.status <= jb.status;
        out_data.history_count <= jb.count;
        out_data.abs_error_sum <= jb.abs_sum;
      end
      default: begin
      end
    endcase
  end

endmodule
